>>> hdl/sjb_pkg.sv
// ---------------------------------------------------------------------------
// sjb_pkg
// Shared types, widths and codes for the sequence jitter buffer.
// ---------------------------------------------------------------------------
package sjb_pkg;

   localparam int DEPTH_DEFAULT = 32;
   localparam int MIN_ENTRIES   = 10;
   localparam int SEQ_W         = 16;
   localparam int HDL_W         = 10;
   localparam int CFG_W         = 6;
   localparam int OUT_CNT_W     = 6;
   localparam int CFG_RESET     = 10;

   // request function
   typedef enum logic {
      FN_ENQUEUE = 1'b0,
      FN_DEQUEUE = 1'b1
   } func_type;

   // response status codes
   typedef enum logic [1:0] {
      ST_PLAY      = 2'd0,
      ST_CONCEAL   = 2'd1,
      ST_ENQUEUED  = 2'd2,
      ST_DUPLICATE = 2'd3
   } status_type;

   // controller states
   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic       latch;
      logic       pop;
      logic       insert;
      logic       drop_new;
      logic       drop_inc;
      logic       exp_inc;
      logic       exp_set;
      logic       rsp_load;
      status_type rsp_status;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      func_type func;
      logic     pending;
      logic     dup;
      logic     empty;
      logic     over_new;
      logic     over;
      logic     head_lt_new;
      logic     head_eq_exp;
      logic     head_gt_exp;
      logic     exp_none;
      logic     rsp_free;
   } stat_type;

endpackage

>>> hdl/sjb_req_if.sv
// ---------------------------------------------------------------------------
// sjb_req_if
// Request channel: enqueue or dequeue words with valid/ready handshake.
// ---------------------------------------------------------------------------
interface sjb_req_if import sjb_pkg::*; ();

   logic             valid;
   logic             ready;
   func_type         func;
   logic [SEQ_W-1:0] seq_num;
   logic [HDL_W-1:0] frame_handle;

   modport source (output valid, output func, output seq_num, output frame_handle,
                   input ready);
   modport sink   (input valid, input func, input seq_num, input frame_handle,
                   output ready);

endinterface

>>> hdl/sjb_rsp_if.sv
// ---------------------------------------------------------------------------
// sjb_rsp_if
// Response channel: one result word per request, valid/ready handshake.
// ---------------------------------------------------------------------------
interface sjb_rsp_if import sjb_pkg::*; ();

   logic                 valid;
   logic                 ready;
   status_type           status;
   logic [HDL_W-1:0]     out_handle;
   logic [SEQ_W-1:0]     out_seq;
   logic [OUT_CNT_W-1:0] occupancy;
   logic [OUT_CNT_W-1:0] dropped;

   modport source (output valid, output status, output out_handle, output out_seq,
                   output occupancy, output dropped, input ready);
   modport sink   (input valid, input status, input out_handle, input out_seq,
                   input occupancy, input dropped, output ready);

endinterface

>>> hdl/sjb_ctrl.sv
// ---------------------------------------------------------------------------
// sjb_ctrl
// Controller: takes a request, then steps the datapath one action per cycle
// (drop, insert, pop, play, conceal) until the free response reg is loaded.
// ---------------------------------------------------------------------------
module sjb_ctrl import sjb_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            if (stat.func == FN_ENQUEUE) begin
               if (stat.pending && stat.dup) begin
                  // duplicate leaves the buffer untouched
                  if (stat.rsp_free) begin
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = ST_DUPLICATE;
                     state_in       = S_IDLE;
                  end
               end else if (stat.pending && stat.over_new) begin
                  // overflow: drop whichever is oldest, head or new frame
                  cmd.drop_inc = 1'b1;
                  if (!stat.empty && stat.head_lt_new) begin
                     cmd.pop = 1'b1;
                  end else begin
                     cmd.drop_new = 1'b1;
                  end
               end else if (stat.pending) begin
                  if (stat.rsp_free) begin
                     cmd.insert     = 1'b1;
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = ST_ENQUEUED;
                     state_in       = S_IDLE;
                  end
               end else if (stat.over) begin
                  // limit was lowered: keep trimming the head
                  cmd.pop      = 1'b1;
                  cmd.drop_inc = 1'b1;
               end else if (stat.rsp_free) begin
                  cmd.rsp_load   = 1'b1;
                  cmd.rsp_status = ST_ENQUEUED;
                  state_in       = S_IDLE;
               end
            end else begin
               if (stat.empty) begin
                  if (stat.rsp_free) begin
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = ST_CONCEAL;
                     state_in       = S_IDLE;
                  end
               end else if (stat.head_eq_exp || stat.exp_none) begin
                  if (stat.rsp_free) begin
                     cmd.pop        = 1'b1;
                     cmd.exp_set    = 1'b1;
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = ST_PLAY;
                     state_in       = S_IDLE;
                  end
               end else if (stat.head_gt_exp) begin
                  // gap ahead of the head: conceal and move on
                  if (stat.rsp_free) begin
                     cmd.exp_inc    = 1'b1;
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = ST_CONCEAL;
                     state_in       = S_IDLE;
                  end
               end else begin
                  // late head
                  cmd.pop      = 1'b1;
                  cmd.drop_inc = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

>>> hdl/sjb_dpath.sv
// ---------------------------------------------------------------------------
// sjb_dpath
// Datapath: sorted compare-and-shift cell row, counters, expected number,
// limit register and the response output register.
// ---------------------------------------------------------------------------
module sjb_dpath import sjb_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CFG_W-1:0]     csr_wr_data,
   input  func_type             req_func,
   input  logic [SEQ_W-1:0]     req_seq_num,
   input  logic [HDL_W-1:0]     req_frame_handle,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output status_type           rsp_status,
   output logic [HDL_W-1:0]     rsp_out_handle,
   output logic [SEQ_W-1:0]     rsp_out_seq,
   output logic [OUT_CNT_W-1:0] rsp_occupancy,
   output logic [OUT_CNT_W-1:0] rsp_dropped,
   input  cmd_type              cmd,
   output stat_type             stat
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int LW = ((CW > CFG_W) ? CW : CFG_W) + 1;

   // cell row, oldest entry at index 0
   logic [SEQ_W-1:0] seq_ff [DEPTH];
   logic [HDL_W-1:0] hdl_ff [DEPTH];

   logic [CFG_W-1:0]     max_ff;
   logic [CW-1:0]        count_ff, count_in;
   logic [SEQ_W-1:0]     exp_ff, exp_in;
   logic [OUT_CNT_W-1:0] drop_ff, drop_in;
   logic                 pending_ff, pending_in;
   func_type             func_ff;
   logic [SEQ_W-1:0]     new_seq_ff;
   logic [HDL_W-1:0]     new_hdl_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff;
   logic [HDL_W-1:0]     rsp_handle_ff;
   logic [SEQ_W-1:0]     rsp_seq_ff;
   logic [OUT_CNT_W-1:0] rsp_occ_ff;
   logic [OUT_CNT_W-1:0] rsp_drop_ff;

   logic [DEPTH-1:0] less_w;
   logic [DEPTH-1:0] equal_w;
   logic [LW-1:0]    lim_w;
   logic [LW-1:0]    count_ext_w;

   // per-cell compare against the new word
   for (genvar i = 0; i < DEPTH; i++) begin : g_cmp
      logic valid_w;
      assign valid_w    = CW'(i) < count_ff;
      assign less_w[i]  = valid_w && (seq_ff[i] < new_seq_ff);
      assign equal_w[i] = valid_w && (seq_ff[i] == new_seq_ff);
   end

   // per-cell shift: pop moves down, insert opens a slot and moves up
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [SEQ_W-1:0] up_seq, dn_seq;
      logic [HDL_W-1:0] up_hdl, dn_hdl;
      logic             ins_here;

      if (i == DEPTH - 1) begin : g_last
         assign up_seq = seq_ff[i];
         assign up_hdl = hdl_ff[i];
      end else begin : g_inner
         assign up_seq = seq_ff[i+1];
         assign up_hdl = hdl_ff[i+1];
      end

      if (i == 0) begin : g_first
         assign ins_here = 1'b1;
         assign dn_seq   = new_seq_ff;
         assign dn_hdl   = new_hdl_ff;
      end else begin : g_rest
         assign ins_here = less_w[i-1];
         assign dn_seq   = seq_ff[i-1];
         assign dn_hdl   = hdl_ff[i-1];
      end

      always_ff @(posedge clock) begin
         if (cmd.pop) begin
            seq_ff[i] <= up_seq;
            hdl_ff[i] <= up_hdl;
         end else if (cmd.insert && !less_w[i]) begin
            seq_ff[i] <= ins_here ? new_seq_ff : dn_seq;
            hdl_ff[i] <= ins_here ? new_hdl_ff : dn_hdl;
         end
      end
   end

   // effective limit: at least ten, at most the row depth
   always_comb begin
      if (LW'(max_ff) < LW'(MIN_ENTRIES)) begin
         lim_w = LW'(MIN_ENTRIES);
      end else if (LW'(max_ff) > LW'(DEPTH)) begin
         lim_w = LW'(DEPTH);
      end else begin
         lim_w = LW'(max_ff);
      end
   end

   assign count_ext_w = LW'(count_ff);

   // status to controller
   always_comb begin
      stat.func        = func_ff;
      stat.pending     = pending_ff;
      stat.dup         = |equal_w;
      stat.empty       = (count_ff == '0);
      stat.over_new    = (count_ext_w + LW'(1)) > lim_w;
      stat.over        = count_ext_w > lim_w;
      stat.head_lt_new = seq_ff[0] < new_seq_ff;
      stat.head_eq_exp = seq_ff[0] == exp_ff;
      stat.head_gt_exp = seq_ff[0] > exp_ff;
      stat.exp_none    = (exp_ff == '0);
      stat.rsp_free    = !rsp_valid_ff || rsp_ready;
   end

   // next values of the control registers
   always_comb begin
      count_in = count_ff;
      if (cmd.pop) begin
         count_in = count_ff - CW'(1);
      end else if (cmd.insert) begin
         count_in = count_ff + CW'(1);
      end

      exp_in = exp_ff;
      if (cmd.exp_set) begin
         exp_in = seq_ff[0] + SEQ_W'(1);
      end else if (cmd.exp_inc) begin
         exp_in = exp_ff + SEQ_W'(1);
      end

      drop_in = drop_ff;
      if (cmd.latch) begin
         drop_in = '0;
      end else if (cmd.drop_inc) begin
         drop_in = drop_ff + OUT_CNT_W'(1);
      end

      pending_in = pending_ff;
      if (cmd.latch) begin
         pending_in = 1'b1;
      end else if (cmd.insert || cmd.drop_new) begin
         pending_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff       <= CFG_W'(CFG_RESET);
         count_ff     <= '0;
         exp_ff       <= '0;
         drop_ff      <= '0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            max_ff <= csr_wr_data;
         end
         count_ff     <= count_in;
         exp_ff       <= exp_in;
         drop_ff      <= drop_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request word latch
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         func_ff    <= req_func;
         new_seq_ff <= req_seq_num;
         new_hdl_ff <= req_frame_handle;
      end
   end

   // response word register
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_occ_ff    <= OUT_CNT_W'(count_in);
         rsp_drop_ff   <= drop_ff;
         if (cmd.rsp_status == ST_PLAY) begin
            rsp_handle_ff <= hdl_ff[0];
            rsp_seq_ff    <= seq_ff[0];
         end else begin
            rsp_handle_ff <= '0;
            rsp_seq_ff    <= '0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_out_handle = rsp_handle_ff;
   assign rsp_out_seq    = rsp_seq_ff;
   assign rsp_occupancy  = rsp_occ_ff;
   assign rsp_dropped    = rsp_drop_ff;

endmodule

>>> hdl/sequence_jitter_buffer.sv
// A request is latched, then its result word is loaded into the response
// register, after a step for each entry dropped on overflow or each late
// head discarded on dequeue. No new request is taken until then; the
// cell row moves one shift per cycle; an insert waits for a free response.
// Reset clears the entry count, the expected number and the response valid,
// and sets the limit to ten; the cell row is not cleared.
// ---------------------------------------------------------------------------
// sequence_jitter_buffer
// Reorder buffer for audio frames kept sorted by sequence number, with
// in-order insert, duplicate discard, overflow trimming and playout control.
// ---------------------------------------------------------------------------
module sequence_jitter_buffer import sjb_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [CFG_W-1:0] csr_wr_data,
   sjb_req_if.sink          req_ch,
   sjb_rsp_if.source        rsp_ch
);

   cmd_type  cmd;
   stat_type stat;
   logic     ctl_req_ready;

   // controller
   sjb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (ctl_req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath
   sjb_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_func         (req_ch.func),
      .req_seq_num      (req_ch.seq_num),
      .req_frame_handle (req_ch.frame_handle),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_status       (rsp_ch.status),
      .rsp_out_handle   (rsp_ch.out_handle),
      .rsp_out_seq      (rsp_ch.out_seq),
      .rsp_occupancy    (rsp_ch.occupancy),
      .rsp_dropped      (rsp_ch.dropped),
      .cmd              (cmd),
      .stat             (stat)
   );

   assign req_ch.ready = ctl_req_ready;

endmodule
